[sv/rgb9e5_pkg.sv]
`default_nettype none
package rgb9e5_pkg;
    localparam int MantBits = 9;
    localparam logic [31:0] MaxRgb9e5 = 32'h477f8000;
    localparam logic [31:0] F32Pinf = 32'h7f800000;
    localparam logic [31:0] F32One = 32'h3f800000;

    typedef enum logic {ACT_PACK = 1'b0, ACT_UNPACK = 1'b1} action_t;

    function automatic logic [31:0] clamp_channel(input logic [31:0] u);
        logic [31:0] r;
        r = u;
        if (u > F32Pinf)
        begin
            r = 32'd0;
        end
        else if (u > MaxRgb9e5)
        begin
            r = MaxRgb9e5;
        end
        return r;
    endfunction

    // floor(value * 2^k) then round half up; u clamped so result small
    // k = 136 - e, e >= 111 ; sh = eff - 150 + k = eff - e - 14
    function automatic logic [8:0] round_mant(input logic [31:0] u, input logic [7:0] es8);
        logic [7:0] e;
        logic [23:0] sig;
        logic [9:0] sh;
        logic [31:0] m;
        logic [9:0] rnd;
        e = u[30:23];
        sig = {(e != 8'd0), u[22:0]};
        // sh = eff - 127 - 23 + k, k = 25 - es, es = e_shared + 1 - 112
        sh = {2'b00, ((e == 8'd0) ? 8'd1 : e)} + 10'd25 - {2'b00, es8} - 10'd150;
        if (!sh[9])
        begin
            m = {8'd0, sig} << ((sh > 10'd8) ? 4'd8 : sh[3:0]);
        end
        else if ((~sh + 10'd1) >= 10'd32)
        begin
            m = 32'd0;
        end
        else
        begin
            m = {8'd0, sig} >> (~sh[4:0] + 5'd1);
        end
        rnd = {9'd0, m[0]} + m[10:1];
        return rnd[8:0];
    endfunction

    function automatic logic [31:0] unpack_one(input logic [8:0] m, input logic [4:0] es);
        logic [3:0] p;
        logic [7:0] biased;
        logic [31:0] sh;
        p = 4'd0;
        for (int i = 1; i < MantBits; i++)
        begin
            if (m[i])
            begin
                p = 4'(i);
            end
        end
        biased = {4'd0, p} + {3'd0, es} + 8'd103;
        sh = {23'd0, m} << (5'd23 - {1'b0, p});
        return (m == 9'd0) ? 32'd0 : {1'b0, biased, sh[22:0]};
    endfunction
endpackage
`default_nettype wire

[sv/rgb9e5_shared_exponent_convert.sv]
// channel | dir | tdata fields (low first) | tuser
// s_axis  | in  | red_bits, green_bits, blue_bits, shared_word | action
// m_axis  | out | packed_out, red_out, green_out, blue_out, alpha_out | -
// one item per cycle unless the output stalls, through three register stages
// stage 1 clamps and finds the largest channel, stage 2 rounds the exponent,
// stage 3 scales mantissas or unpacks; reset clears the valid bits only
// a stall holds each full stage, empty stages ahead of it still fill
// tready follows the room in the stages, back to the output's tready
`default_nettype none
module rgb9e5_shared_exponent_convert (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [127:0] s_axis_tdata,  // red, green, blue, shared_word
    input  wire logic         s_axis_tuser,  // action
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [159:0]      m_axis_tdata   // packed, red, green, blue, alpha
);
    import rgb9e5_pkg::*;

    logic v1_reg, v2_reg, v3_reg;
    logic en1, en2, en3;
    logic a1_reg, a2_reg;
    logic [31:0] r1_reg, g1_reg, b1_reg, w1_reg, mx1_reg;
    logic [31:0] r2_reg, g2_reg, b2_reg, w2_reg;
    logic [7:0] es2_reg;
    logic [159:0] d3_reg;
    logic [31:0] rc, gc, bc, mx, mxr;
    logic [7:0] e, es_next;
    logic [159:0] d3_next;

    assign en3 = !v3_reg || m_axis_tready;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign s_axis_tready = en1;
    assign m_axis_tvalid = v3_reg;
    assign m_axis_tdata = d3_reg;

    always_comb
    begin
        rc = clamp_channel(s_axis_tdata[31:0]);
        gc = clamp_channel(s_axis_tdata[63:32]);
        bc = clamp_channel(s_axis_tdata[95:64]);
        mx = (rc > gc) ? rc : gc;
        mx = (mx > bc) ? mx : bc;
        mxr = mx1_reg + (mx1_reg & 32'h4000);
        e = mxr[30:23];
        if (e < 8'd111)
        begin
            e = 8'd111;
        end
        es_next = e - 8'd111;
        if (a2_reg == ACT_PACK)
        begin
            d3_next = {128'd0, es2_reg[4:0], round_mant(b2_reg, es2_reg),
                       round_mant(g2_reg, es2_reg), round_mant(r2_reg, es2_reg)};
        end
        else
        begin
            d3_next = {F32One, unpack_one(w2_reg[26:18], w2_reg[31:27]),
                       unpack_one(w2_reg[17:9], w2_reg[31:27]),
                       unpack_one(w2_reg[8:0], w2_reg[31:27]), 32'd0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg <= s_axis_tvalid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            a1_reg <= s_axis_tuser;
            r1_reg <= rc;
            g1_reg <= gc;
            b1_reg <= bc;
            w1_reg <= s_axis_tdata[127:96];
            mx1_reg <= mx;
        end
        if (en2)
        begin
            a2_reg <= a1_reg;
            r2_reg <= r1_reg;
            g2_reg <= g1_reg;
            b2_reg <= b1_reg;
            w2_reg <= w1_reg;
            es2_reg <= es_next;
        end
        if (en3)
        begin
            d3_reg <= d3_next;
        end
    end
endmodule
`default_nettype wire

[sv/rgb9e5_chk.sv]
`default_nettype none
module rgb9e5_chk (
    input wire logic         clk,
    input wire logic         rst_n,
    input wire logic         s_axis_tvalid,
    input wire logic         s_axis_tready,
    input wire logic         m_axis_tvalid,
    input wire logic         m_axis_tready,
    input wire logic [159:0] m_axis_tdata
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output dropped under stall");
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tready |-> s_axis_tready)
        else $error("input stalled with free output");
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[31:0] != 32'd0 |-> m_axis_tdata[159:32] == 128'd0)
        else $error("pack item has float fields");
    a_alpha: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[159:128] == 32'd0
                       || m_axis_tdata[159:128] == 32'h3f800000)
        else $error("bad alpha");
endmodule
bind rgb9e5_shared_exponent_convert rgb9e5_chk u_chk (.*);
`default_nettype wire

[tb/tb_rgb9e5_shared_exponent_convert.sv]
`default_nettype none
module tb_rgb9e5_shared_exponent_convert;
    timeunit 1ns;
    timeprecision 1ps;
    import rgb9e5_pkg::*;

    typedef struct packed {
        action_t     action;
        logic [31:0] red_bits;
        logic [31:0] green_bits;
        logic [31:0] blue_bits;
        logic [31:0] shared_word;
    } texel_t;

    typedef struct packed {
        logic [31:0] packed_out;
        logic [31:0] red_out;
        logic [31:0] green_out;
        logic [31:0] blue_out;
        logic [31:0] alpha_out;
    } conv_t;

    logic           clk = 1'b0;
    logic           rst_n = 1'b0;
    logic           s_axis_tvalid = 1'b0;
    logic           s_axis_tready;
    logic [127:0]   s_axis_tdata = '0;
    logic           s_axis_tuser = 1'b0;
    logic           m_axis_tvalid;
    logic           m_axis_tready = 1'b0;
    logic [159:0]   m_axis_tdata;

    texel_t texel_q[$];
    conv_t  conv_q[$];
    int     errors = 0;
    int     n_pack = 0;
    int     n_unpack = 0;
    int     n_checked = 0;
    int     send_gap = 0;
    int     recv_gap = 0;
    bit     drain_hold = 1'b0;
    bit     in_fire = 1'b0;

    rgb9e5_shared_exponent_convert u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #2 clk = ~clk;

    function automatic logic [31:0] sanitise(input logic [31:0] u);
        if (u > 32'h7f800000)
        begin
            return 32'd0;
        end
        if (u > 32'h477f8000)
        begin
            return 32'h477f8000;
        end
        return u;
    endfunction

    // floor(value * 2^k) with shift cap, then round half up
    function automatic logic [8:0] scale_mant(input logic [31:0] u, input int k);
        int          eff;
        int          sh;
        logic [31:0] sig;
        logic [31:0] m;
        sig = {9'd0, u[22:0]};
        if (u[30:23] == 8'd0)
        begin
            eff = 1;
        end
        else
        begin
            eff = int'(u[30:23]);
            sig[23] = 1'b1;
        end
        sh = eff - 150 + k;
        if (sh >= 0)
        begin
            m = sig << ((sh > 8) ? 8 : sh);
        end
        else if (-sh >= 32)
        begin
            m = 32'd0;
        end
        else
        begin
            m = sig >> (-sh);
        end
        m = (m & 32'd1) + (m >> 1);
        return m[8:0];
    endfunction

    function automatic logic [31:0] to_single(input logic [8:0] m, input logic [4:0] es);
        int          p;
        logic [7:0]  biased;
        logic [31:0] frac;
        if (m == 9'd0)
        begin
            return 32'd0;
        end
        p = 8;
        while (p > 0 && !m[p])
        begin
            p--;
        end
        biased = 8'(p + int'(es) + 103);
        frac = {23'd0, m} << (23 - p);
        return {1'b0, biased, frac[22:0]};
    endfunction

    function automatic conv_t convert_texel(input texel_t t);
        conv_t       c;
        logic [31:0] r;
        logic [31:0] g;
        logic [31:0] b;
        logic [31:0] mx;
        int          e;
        int          es;
        int          k;
        c = '0;
        if (t.action == ACT_PACK)
        begin
            r = sanitise(t.red_bits);
            g = sanitise(t.green_bits);
            b = sanitise(t.blue_bits);
            mx = (r > g) ? r : g;
            mx = (mx > b) ? mx : b;
            mx = mx + (mx & 32'h4000);
            e = int'(mx >> 23);
            if (e < 111)
            begin
                e = 111;
            end
            es = e - 111;
            k = 25 - es;
            c.packed_out = {5'(es), scale_mant(b, k), scale_mant(g, k), scale_mant(r, k)};
        end
        else
        begin
            c.red_out   = to_single(t.shared_word[8:0], t.shared_word[31:27]);
            c.green_out = to_single(t.shared_word[17:9], t.shared_word[31:27]);
            c.blue_out  = to_single(t.shared_word[26:18], t.shared_word[31:27]);
            c.alpha_out = 32'h3f800000;
        end
        return c;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 55)
        begin
            return 0;
        end
        if (r < 92)
        begin
            return $urandom_range(3, 1);
        end
        return $urandom_range(30, 8);
    endfunction

    // channel values biased towards the format's interesting ranges
    function automatic logic [31:0] rand_channel();
        int sel;
        sel = $urandom_range(9);
        case (sel)
            0: return $urandom();
            1: return {1'b0, 8'($urandom_range(142, 100)), 23'($urandom())};
            2: return {1'b0, 8'($urandom_range(142, 125)), 23'($urandom())};
            3: return {1'b0, 8'($urandom_range(112, 108)), 23'($urandom())};
            4: return {9'd0, 23'($urandom())};
            5: return {1'b1, 31'($urandom())};
            6: return 32'h477f8000 + 32'($urandom_range(4, 0)) - 32'd2;
            7: return {1'b0, 8'($urandom_range(147, 143)), 23'($urandom())};
            default: return {1'b0, 8'($urandom_range(142, 112)), 9'($urandom()), 14'h2000};
        endcase
    endfunction

    function automatic texel_t make_pack(input logic [31:0] r, input logic [31:0] g,
                                         input logic [31:0] b);
        texel_t t;
        t.action = ACT_PACK;
        t.red_bits = r;
        t.green_bits = g;
        t.blue_bits = b;
        t.shared_word = $urandom();
        return t;
    endfunction

    function automatic texel_t make_unpack(input logic [31:0] w);
        texel_t t;
        t.action = ACT_UNPACK;
        t.red_bits = $urandom();
        t.green_bits = $urandom();
        t.blue_bits = $urandom();
        t.shared_word = w;
        return t;
    endfunction

    // driver
    always @(negedge clk)
    begin
        texel_t t;
        if (rst_n)
        begin
            if (in_fire)
            begin
                conv_q.push_back(convert_texel(texel_q.pop_front()));
                send_gap = pick_gap();
            end
            if (s_axis_tvalid && !in_fire)
            begin
            end
            else if (send_gap > 0)
            begin
                send_gap--;
                s_axis_tvalid <= 1'b0;
            end
            else if (texel_q.size() > 0 && !drain_hold)
            begin
                t = texel_q[0];
                s_axis_tvalid <= 1'b1;
                s_axis_tuser <= t.action;
                s_axis_tdata <= {t.shared_word, t.blue_bits, t.green_bits, t.red_bits};
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
            if (recv_gap > 0)
            begin
                recv_gap--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                if ($urandom_range(9) == 0)
                begin
                    recv_gap = pick_gap();
                end
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        conv_t got;
        conv_t want;
        in_fire = rst_n && s_axis_tvalid && s_axis_tready;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = {m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tdata[95:64],
                   m_axis_tdata[127:96], m_axis_tdata[159:128]};
            if (conv_q.size() == 0)
            begin
                $error("result with nothing outstanding: %h", m_axis_tdata);
                errors++;
            end
            else
            begin
                want = conv_q.pop_front();
                n_checked++;
                if (got.packed_out !== want.packed_out)
                begin
                    $error("packed_out expected %h actual %h", want.packed_out, got.packed_out);
                    errors++;
                end
                if (got.red_out !== want.red_out)
                begin
                    $error("red_out expected %h actual %h", want.red_out, got.red_out);
                    errors++;
                end
                if (got.green_out !== want.green_out)
                begin
                    $error("green_out expected %h actual %h", want.green_out, got.green_out);
                    errors++;
                end
                if (got.blue_out !== want.blue_out)
                begin
                    $error("blue_out expected %h actual %h", want.blue_out, got.blue_out);
                    errors++;
                end
                if (got.alpha_out !== want.alpha_out)
                begin
                    $error("alpha_out expected %h actual %h", want.alpha_out, got.alpha_out);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        #2000000;
        $display("rgb9e5_shared_exponent_convert regression: fail");
        $finish;
    end

    initial
    begin
        int     i;
        texel_t t;
        // directed: zeros, extremes, negatives, nan, inf, saturation, denormals, then unpack words
        texel_q.push_back(make_pack(32'h0, 32'h0, 32'h0));
        texel_q.push_back(make_pack(32'h7f800000, 32'h7f800001, 32'hffffffff));
        texel_q.push_back(make_pack(32'h80000000, 32'hbf800000, 32'h3f800000));
        texel_q.push_back(make_pack(32'h477f8000, 32'h477f8001, 32'h477fffff));
        texel_q.push_back(make_pack(32'h477f7fff, 32'h3f000000, 32'h00000001));
        texel_q.push_back(make_pack(32'h007fffff, 32'h00400000, 32'h00000001));
        texel_q.push_back(make_pack(32'h37800000, 32'h37000000, 32'h33800000));
        texel_q.push_back(make_pack(32'h3f7fc000, 32'h3f7fbfff, 32'h3e000000));
        texel_q.push_back(make_pack(32'h7fffffff, 32'h55555555, 32'haaaaaaaa));
        texel_q.push_back(make_pack(32'h3fffc000, 32'h0, 32'h3f804000));
        texel_q.push_back(make_unpack(32'h0));
        texel_q.push_back(make_unpack(32'hffffffff));
        texel_q.push_back(make_unpack(32'h07ffffff));
        texel_q.push_back(make_unpack(32'hf8000000));
        texel_q.push_back(make_unpack(32'h80040201));
        texel_q.push_back(make_unpack(32'h55555555));
        texel_q.push_back(make_unpack(32'haaaaaaaa));
        texel_q.push_back(make_unpack(32'h7c0201ff));
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        wait (texel_q.size() == 0);
        // hold the sender until everything has drained
        drain_hold = 1'b1;
        wait (conv_q.size() == 0);
        drain_hold = 1'b0;
        for (i = 0; i < 1880; i++)
        begin
            if ($urandom_range(1) == 0)
            begin
                t = make_pack(rand_channel(), rand_channel(), rand_channel());
            end
            else
            begin
                t = make_unpack($urandom());
            end
            if (t.action == ACT_PACK)
            begin
                n_pack++;
            end
            else
            begin
                n_unpack++;
            end
            texel_q.push_back(t);
            if (i == 900)
            begin
                wait (texel_q.size() == 0);
                drain_hold = 1'b1;
                wait (conv_q.size() == 0);
                drain_hold = 1'b0;
            end
        end
        wait (texel_q.size() == 0 && !s_axis_tvalid);
        wait (conv_q.size() == 0);
        repeat (10) @(posedge clk);
        $display("checked %0d items: %0d random packs, %0d random unpacks plus directed cases",
                 n_checked, n_pack, n_unpack);
        if (errors == 0)
        begin
            $display("rgb9e5_shared_exponent_convert regression: pass");
        end
        else
        begin
            $display("rgb9e5_shared_exponent_convert regression: fail");
        end
        $finish;
    end
endmodule
`default_nettype wire

[filelist.f]
sv/rgb9e5_pkg.sv
sv/rgb9e5_shared_exponent_convert.sv
sv/rgb9e5_chk.sv
tb/tb_rgb9e5_shared_exponent_convert.sv
